/* rtl/core/lz4hc_pkg.sv */
// lz4hc_pkg: shared types and constants for the LZ4 history copy engine.
// No dependencies; imported by the channel interfaces and every module except lz4hc_ram.
`timescale 1ns / 1ps

package lz4hc_pkg;

   localparam int BYTE_W = 8;
   localparam int OFF_W  = 16;
   localparam int LEN_W  = 7;

   localparam logic CMD_LITERAL = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic lit_load;   // write literal, load output
      logic err_load;   // load error result
      logic start;      // set up match, issue first read
      logic emit;       // write copied byte, load output
      logic read_next;  // issue next history read
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic more_left;
      logic is_literal;
      logic off_zero;
      logic len_zero;
   } ctrl_status_type;

endpackage

/* rtl/core/lz4hc_req_if.sv */
// lz4hc_req_if: input channel carrying literal and match items.
// Depends on lz4hc_pkg for field widths.
`timescale 1ns / 1ps

interface lz4hc_req_if;
   import lz4hc_pkg::*;

   logic               valid;
   logic               ready;
   logic               cmd;
   logic [BYTE_W-1:0]  lit_byte;
   logic               run_end;
   logic [OFF_W-1:0]   match_offset;
   logic [LEN_W-1:0]   match_length;

   modport source (output valid, cmd, lit_byte, run_end, match_offset, match_length,
                   input ready);
   modport sink   (input valid, cmd, lit_byte, run_end, match_offset, match_length,
                   output ready);
endinterface

/* rtl/core/lz4hc_rsp_if.sv */
// lz4hc_rsp_if: result channel carrying decompressed bytes.
// Depends on lz4hc_pkg for field widths.
`timescale 1ns / 1ps

interface lz4hc_rsp_if;
   import lz4hc_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               last;
   logic               error;

   modport source (output valid, out_byte, last, error, input ready);
   modport sink   (input valid, out_byte, last, error, output ready);
endinterface

/* rtl/core/lz4_history_copy_engine_top.sv */
// LZ4 history copy engine: literal result in the next cycle, one item per cycle while
// the output is free. Match (length saturated to MAX_RUN): first byte after the RAM read
// and output registers, then one byte per cycle while the output is free; ready is low
// until the last byte. Zero-offset matches give an error result; zero-length ones are
// dropped. HISTORY_DEPTH must be a power of two, unchecked. Reset clears the write
// position, fill tracking; unwritten history reads as zero, so items are taken at once.
`timescale 1ns / 1ps

module lz4_history_copy_engine_top #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int MAX_RUN       = 64
) (
   input  logic        clock,
   input  logic        reset,
   lz4hc_req_if.sink   req_ch,
   lz4hc_rsp_if.source rsp_ch
);
   import lz4hc_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;

   lz4hc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lz4hc_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_RUN       (MAX_RUN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_ch.cmd),
      .req_lit_byte     (req_ch.lit_byte),
      .req_run_end      (req_ch.run_end),
      .req_match_offset (req_ch.match_offset),
      .req_match_length (req_ch.match_length),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_out_byte     (rsp_ch.out_byte),
      .rsp_last         (rsp_ch.last),
      .rsp_error        (rsp_ch.error),
      .cmd              (cmd),
      .status           (status)
   );

   assign req_ch.ready = req_ready;
endmodule

/* rtl/core/lz4hc_ram.sv */
// lz4hc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lz4hc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/lz4hc_ctrl.sv */
// lz4hc_ctrl: sequencer for literal, error and match-copy items.
// Depends on lz4hc_pkg; drives lz4hc_datapath through command and status structs.
`timescale 1ns / 1ps

module lz4hc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lz4hc_pkg::ctrl_status_type status,
   output lz4hc_pkg::ctrl_cmd_type    cmd
);
   import lz4hc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               if (status.is_literal) begin
                  cmd.lit_load = 1'b1;
               end else if (status.off_zero) begin
                  cmd.err_load = 1'b1;
               end else if (!status.len_zero) begin
                  cmd.start = 1'b1;
                  state_in  = ST_COPY;
               end
            end
         end
         ST_COPY: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.more_left) begin
                  cmd.read_next = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* rtl/core/lz4hc_datapath.sv */
// lz4hc_datapath: history RAM, write/read pointers, forwarding and output register.
// Depends on lz4hc_pkg and lz4hc_ram; commanded by lz4hc_ctrl.
`timescale 1ns / 1ps

module lz4hc_datapath #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int MAX_RUN       = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_cmd,
   input  logic [lz4hc_pkg::BYTE_W-1:0]  req_lit_byte,
   input  logic                          req_run_end,
   input  logic [lz4hc_pkg::OFF_W-1:0]   req_match_offset,
   input  logic [lz4hc_pkg::LEN_W-1:0]   req_match_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lz4hc_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_last,
   output logic                          rsp_error,
   input  lz4hc_pkg::ctrl_cmd_type       cmd,
   output lz4hc_pkg::ctrl_status_type    status
);
   import lz4hc_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int LW = $clog2(MAX_RUN + 1);

   logic [AW-1:0]     wp_ff, wp_in;
   logic              wrapped_ff, wrapped_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [LW-1:0]     left_ff, left_in;
   logic              hit_ff;
   logic              fresh_ff;
   logic [BYTE_W-1:0] fwd_ff;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_error_ff, out_error_in;

   logic [AW-1:0]     src_start;
   logic [AW-1:0]     rd_addr;
   logic              rd_en;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] ram_q;
   logic [BYTE_W-1:0] copy_byte;
   logic [LEN_W-1:0]  len_sat;
   logic              out_load;

   assign src_start = wp_ff - AW'(req_match_offset);
   assign len_sat   = (req_match_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN)
                                                           : req_match_length;

   assign rd_en   = cmd.start | cmd.read_next;
   assign rd_addr = cmd.start ? src_start : src_ff;
   assign wr_en   = cmd.lit_load | cmd.emit;

   // unwritten entries read as zero; same-cycle write is forwarded
   assign copy_byte = hit_ff ? fwd_ff : (fresh_ff ? ram_q : '0);
   assign wr_data   = cmd.lit_load ? req_lit_byte : copy_byte;

   lz4hc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign out_load = cmd.lit_load | cmd.err_load | cmd.emit;

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (wr_en) begin
         wp_in = wp_ff + AW'(1);
         if (&wp_ff) begin
            wrapped_in = 1'b1;
         end
      end

      src_in  = src_ff;
      left_in = left_ff;
      if (cmd.start) begin
         src_in  = src_start + AW'(1);
         left_in = LW'(len_sat - LEN_W'(1));
      end else if (cmd.read_next) begin
         src_in  = src_ff + AW'(1);
         left_in = left_ff - LW'(1);
      end

      out_valid_in = out_valid_ff & ~rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      priority if (cmd.lit_load) begin
         out_byte_in  = req_lit_byte;
         out_last_in  = req_run_end;
         out_error_in = 1'b0;
      end else if (cmd.err_load) begin
         out_byte_in  = '0;
         out_last_in  = 1'b1;
         out_error_in = 1'b1;
      end else if (cmd.emit) begin
         out_byte_in  = copy_byte;
         out_last_in  = (left_ff == '0);
         out_error_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      left_ff      <= left_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
      if (rd_en) begin
         hit_ff   <= wr_en && (rd_addr == wp_ff);
         fwd_ff   <= wr_data;
         fresh_ff <= wrapped_ff || (rd_addr < wp_ff);
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_error    = out_error_ff;

   assign status.out_free   = ~out_valid_ff | rsp_ready;
   assign status.more_left  = (left_ff != '0);
   assign status.is_literal = (req_cmd == CMD_LITERAL);
   assign status.off_zero   = (req_match_offset == '0);
   assign status.len_zero   = (req_match_length == '0);
endmodule
